// ===== rtl/ccc_pkg.sv =====
// Shared types, constants and the month length table for the calendar counter.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package ccc_pkg;

  // Operation codes carried by the operation field of an input word.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Limits of the time and date fields.
  localparam logic [5:0]  MAX_SECOND  = 6'd59;
  localparam logic [5:0]  MAX_MINUTE  = 6'd59;
  localparam logic [4:0]  MAX_HOUR    = 5'd23;
  localparam logic [2:0]  MAX_WEEKDAY = 3'd6;
  localparam logic [4:0]  MIN_DAY     = 5'd1;
  localparam logic [3:0]  MIN_MONTH   = 4'd1;
  localparam logic [3:0]  FEBRUARY    = 4'd2;
  localparam logic [3:0]  MAX_MONTH   = 4'd12;
  localparam logic [15:0] RESET_YEAR  = 16'd2000;

  // Complete calendar state, also the layout of one result word.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] zone;
  } calendar_t;

  // One input word as held in the input register.
  typedef struct packed {
    op_t       operation;
    calendar_t load;
  } request_t;

  // Days in a month of a common year; codes outside 1..12 never occur.
  function automatic logic [4:0] month_length(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/ccc_leap.sv =====
// Gregorian leap year detector for a 16-bit year.
// Depends on ccc_pkg (imported for house consistency only).
`timescale 1ns / 1ps

module ccc_leap (
  input  logic [15:0] year,
  output logic        leap
);
  import ccc_pkg::*;

  // Exact quotient by 25 for any 16-bit year: multiply by ceil(2^22 / 25).
  localparam logic [17:0] RECIP_25 = 18'd167773;
  localparam int          SHIFT_25 = 22;

  logic [33:0] product;
  logic [11:0] quotient;
  logic [16:0] back_mult;
  logic        div4;
  logic        div16;
  logic        div25;

  assign product   = {18'd0, year} * {16'd0, RECIP_25};
  assign quotient  = product[SHIFT_25 +: 12];
  // quotient * 25 as shifts and adds.
  assign back_mult = {1'b0, quotient, 4'd0} + {2'b0, quotient, 3'd0} + {5'd0, quotient};

  assign div4  = (year[1:0] == 2'd0);
  assign div16 = (year[3:0] == 4'd0);
  assign div25 = (back_mult == {1'b0, year});

  // Centuries are divisible by 4 and 25; those divisible by 400 also by 16.
  assign leap = div4 && (!div25 || div16);

endmodule

// ===== rtl/ccc_step.sv =====
// Next-state logic of the calendar: a one-second tick with full carry chain,
// or a clamped load. Depends on ccc_pkg and ccc_leap.
`timescale 1ns / 1ps

module ccc_step (
  input  ccc_pkg::calendar_t current,
  input  ccc_pkg::request_t  request,
  output ccc_pkg::calendar_t updated
);
  import ccc_pkg::*;

  logic       leap;
  logic [4:0] days_in_month;
  logic [5:0] day_inc;
  calendar_t  ticked;
  calendar_t  loaded;

  ccc_leap u_leap (
    .year (current.year),
    .leap (leap)
  );

  always_comb begin
    days_in_month = month_length(current.month);
    if (current.month == FEBRUARY && leap) begin
      days_in_month = days_in_month + 5'd1;
    end
    day_inc = {1'b0, current.day} + 6'd1;
  end

  // Tick: seconds carry into minutes, hours and then the date.
  always_comb begin
    ticked = current;
    if (current.second >= MAX_SECOND) begin
      ticked.second = '0;
      if (current.minute >= MAX_MINUTE) begin
        ticked.minute = '0;
        if (current.hour >= MAX_HOUR) begin
          ticked.hour    = '0;
          ticked.weekday = (current.weekday >= MAX_WEEKDAY) ? 3'd0 : current.weekday + 3'd1;
          // A loaded day beyond the month length also rolls over here.
          if (day_inc > {1'b0, days_in_month}) begin
            ticked.day = MIN_DAY;
            if (current.month >= MAX_MONTH) begin
              ticked.month = MIN_MONTH;
              ticked.year  = current.year + 16'd1;
            end else begin
              ticked.month = current.month + 4'd1;
            end
          end else begin
            ticked.day = day_inc[4:0];
          end
        end else begin
          ticked.hour = current.hour + 5'd1;
        end
      end else begin
        ticked.minute = current.minute + 6'd1;
      end
    end else begin
      ticked.second = current.second + 6'd1;
    end
  end

  // Load: each field is clamped into its legal range, the day only from below; year and zone as given.
  always_comb begin
    loaded         = request.load;
    if (request.load.month < MIN_MONTH) begin
      loaded.month = MIN_MONTH;
    end else if (request.load.month > MAX_MONTH) begin
      loaded.month = MAX_MONTH;
    end
    if (request.load.day < MIN_DAY) begin
      loaded.day = MIN_DAY;
    end
    if (request.load.weekday > MAX_WEEKDAY) begin
      loaded.weekday = MAX_WEEKDAY;
    end
    if (request.load.hour > MAX_HOUR) begin
      loaded.hour = MAX_HOUR;
    end
    if (request.load.minute > MAX_MINUTE) begin
      loaded.minute = MAX_MINUTE;
    end
    if (request.load.second > MAX_SECOND) begin
      loaded.second = MAX_SECOND;
    end
  end

  assign updated = (request.operation == OP_LOAD) ? loaded : ticked;

endmodule

// ===== rtl/calendar_clock_counter_core.sv =====
// Gregorian calendar counter: each accepted input word is held in the input
// register, its result word in the result register; one word per cycle sustained, with stall on either side.
// Input register, then next-state logic into the calendar and result
// registers. Reset (synchronous, active high) sets 2000-01-01 00:00:00,
// weekday 0, zone 0, and empties both pipeline registers.
`timescale 1ns / 1ps

module calendar_clock_counter_core (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [15:0] new_year,
  input  logic [3:0]  new_month,
  input  logic [4:0]  new_day,
  input  logic [2:0]  new_weekday,
  input  logic [4:0]  new_hour,
  input  logic [5:0]  new_minute,
  input  logic [5:0]  new_second,
  input  logic [15:0] new_zone,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [2:0]  weekday,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [15:0] zone
);
  import ccc_pkg::*;

  // The input register holds one word, the result register one finished
  // word. The calendar registers are the running state; they change only
  // when a word moves from the input register into the result register, so
  // words are applied strictly in arrival order.
  logic      req_valid;
  request_t  req;
  logic      res_valid;
  calendar_t res;
  calendar_t calendar;
  calendar_t calendar_next;

  logic      res_advance;
  logic      req_advance;

  // The result register can take a word when it is empty or being drained.
  assign res_advance = !res_valid || !out_stall;
  // The input register can take a word when it is empty or moving on.
  assign req_advance = !req_valid || res_advance;
  assign in_stall    = !req_advance;

  ccc_step u_step (
    .current (calendar),
    .request (req),
    .updated (calendar_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_advance) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && req_advance) begin
      req.operation    <= op_t'(operation);
      req.load.year    <= new_year;
      req.load.month   <= new_month;
      req.load.day     <= new_day;
      req.load.weekday <= new_weekday;
      req.load.hour    <= new_hour;
      req.load.minute  <= new_minute;
      req.load.second  <= new_second;
      req.load.zone    <= new_zone;
    end
  end

  // Calendar state: updated once per word as it completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      calendar.year    <= RESET_YEAR;
      calendar.month   <= MIN_MONTH;
      calendar.day     <= MIN_DAY;
      calendar.weekday <= '0;
      calendar.hour    <= '0;
      calendar.minute  <= '0;
      calendar.second  <= '0;
      calendar.zone    <= '0;
    end else if (req_valid && res_advance) begin
      calendar <= calendar_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_advance) begin
      res_valid <= req_valid;
    end
  end

  // Each word reports the calendar as it stands after that word.
  always_ff @(posedge clk) begin
    if (req_valid && res_advance) begin
      res <= calendar_next;
    end
  end

  assign out_valid = res_valid;
  assign year      = res.year;
  assign month     = res.month;
  assign day       = res.day;
  assign weekday   = res.weekday;
  assign hour      = res.hour;
  assign minute    = res.minute;
  assign second    = res.second;
  assign zone      = res.zone;

endmodule
